// File: rtl/teq_pkg.sv
// ----------------------------------------------------------------------------
// teq_pkg
// Shared types, constants and helpers for the tap event qualifier.
// ----------------------------------------------------------------------------
package teq_pkg;

    localparam int TIME_BITS   = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int ABS_BITS    = SAMPLE_BITS - 1;
    localparam int WEIGHT_BITS = 8;
    // three products of |sample| * weight
    localparam int SUM_BITS    = ABS_BITS + WEIGHT_BITS + 2;

    localparam int ENERGY_BITS = 16;
    localparam int COUNT_BITS  = 8;
    localparam int MASK_BITS   = 5;

    // divide by 100 as a multiply by a rounded-up reciprocal
    localparam longint unsigned PERCENT      = 100;
    localparam int              RECIP_SHIFT  = 32;
    localparam longint unsigned RECIP_MULT   =
        ((64'd1 << RECIP_SHIFT) + PERCENT - 64'd1) / PERCENT;
    localparam int              RECIP_BITS   = $clog2(RECIP_MULT + 1);
    localparam int              PROD_BITS    = SUM_BITS + RECIP_BITS;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_TH     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENERGY_TH   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_TH   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_NEED = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REBOUND_TH  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS     = 4'd7;

    // fail mask bits
    localparam int FAIL_COOLDOWN = 0;
    localparam int FAIL_PEAK     = 1;
    localparam int FAIL_ENERGY   = 2;
    localparam int FAIL_ACTIVE   = 3;
    localparam int FAIL_REBOUND  = 4;

    typedef struct packed {
        logic [14:0] peak_th;
        logic [15:0] energy_th;
        logic [15:0] active_th;
        logic [7:0]  active_need;
        logic [14:0] rebound_th;
        logic [15:0] cooldown_ms;
        logic [15:0] confirm_ms;
        logic [23:0] weights;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        peak_th:     15'd200,
        energy_th:   16'd1000,
        active_th:   16'd100,
        active_need: 8'd3,
        rebound_th:  15'd100,
        cooldown_ms: 16'd1000,
        confirm_ms:  16'd50,
        weights:     24'h640000
    };

    // one classified sample handed from front to back
    typedef struct packed {
        logic [ENERGY_BITS-1:0]        motion;
        logic [ABS_BITS-1:0]           abs_z;
        logic signed [SAMPLE_BITS-1:0] dz;
        logic [TIME_BITS-1:0]          now;
        logic                          win_done;
    } t_item;

    typedef struct packed {
        logic                   accepted;
        logic [MASK_BITS-1:0]   fault_flags;
        logic [ABS_BITS-1:0]    peak_z;
        logic [ENERGY_BITS-1:0] energy;
        logic [COUNT_BITS-1:0]  active;
        logic                   rebound;
    } t_result;

    // magnitude, with the most negative value clamped to the largest positive
    function automatic logic [ABS_BITS-1:0] abs_clamp(input logic [SAMPLE_BITS-1:0] v);
        logic [SAMPLE_BITS-1:0] mag;
        mag = v[SAMPLE_BITS-1] ? (~v + 1'b1) : v;
        return mag[SAMPLE_BITS-1] ? {ABS_BITS{1'b1}} : mag[ABS_BITS-1:0];
    endfunction

endpackage

// File: rtl/teq_front.sv
// ----------------------------------------------------------------------------
// teq_front
// Three-stage front end: magnitudes and window flag, weighted sum, divide by
// one hundred with saturation. Hands classified items to the queue.
// ----------------------------------------------------------------------------
module teq_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  teq_pkg::t_cfg                     i_cfg,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [teq_pkg::SAMPLE_BITS-1:0]   i_delta_x,
    input  logic [teq_pkg::SAMPLE_BITS-1:0]   i_delta_y,
    input  logic [teq_pkg::SAMPLE_BITS-1:0]   i_delta_z,
    input  logic [teq_pkg::TIME_BITS-1:0]     i_now_ms,
    input  logic [teq_pkg::TIME_BITS-1:0]     i_window_start_ms,
    output logic                              o_push,
    input  logic                              i_push_ready,
    output teq_pkg::t_item                    o_item
);
    import teq_pkg::*;

    logic en1, en2, en3;

    // stage 1
    logic                          r1_v;
    logic [ABS_BITS-1:0]           r1_ax, r1_ay, r1_az;
    logic signed [SAMPLE_BITS-1:0] r1_dz;
    logic [TIME_BITS-1:0]          r1_now;
    logic                          r1_done;
    logic [TIME_BITS-1:0]          elapsed;

    // stage 2
    logic                          r2_v;
    logic [SUM_BITS-1:0]           r2_sum;
    logic [ABS_BITS-1:0]           r2_az;
    logic signed [SAMPLE_BITS-1:0] r2_dz;
    logic [TIME_BITS-1:0]          r2_now;
    logic                          r2_done;
    logic [SUM_BITS-1:0]           px, py, pz;

    // stage 3
    logic                          r3_v;
    t_item                         r3_item;
    logic [PROD_BITS-1:0]          prod;
    logic [31:0]                   quot;
    logic [ENERGY_BITS-1:0]        motion;

    assign en3     = !r3_v || i_push_ready;
    assign en2     = !r2_v || en3;
    assign en1     = !r1_v || en2;
    assign o_ready = en1;

    assign elapsed = i_now_ms - i_window_start_ms;

    assign px = SUM_BITS'(r1_ax) * SUM_BITS'(i_cfg.weights[7:0]);
    assign py = SUM_BITS'(r1_ay) * SUM_BITS'(i_cfg.weights[15:8]);
    assign pz = SUM_BITS'(r1_az) * SUM_BITS'(i_cfg.weights[23:16]);

    assign prod   = PROD_BITS'(r2_sum) * PROD_BITS'(RECIP_MULT[RECIP_BITS-1:0]);
    assign quot   = 32'(prod >> RECIP_SHIFT);
    assign motion = (quot > 32'h0000_FFFF) ? {ENERGY_BITS{1'b1}} : quot[ENERGY_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (en1) r1_v <= i_valid;
            if (en2) r2_v <= r1_v;
            if (en3) r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r1_ax   <= abs_clamp(i_delta_x);
            r1_ay   <= abs_clamp(i_delta_y);
            r1_az   <= abs_clamp(i_delta_z);
            r1_dz   <= i_delta_z;
            r1_now  <= i_now_ms;
            r1_done <= elapsed >= TIME_BITS'(i_cfg.confirm_ms);
        end
        if (en2 && r1_v) begin
            r2_sum  <= px + py + pz;
            r2_az   <= r1_az;
            r2_dz   <= r1_dz;
            r2_now  <= r1_now;
            r2_done <= r1_done;
        end
        if (en3 && r2_v) begin
            r3_item.motion   <= motion;
            r3_item.abs_z    <= r2_az;
            r3_item.dz       <= r2_dz;
            r3_item.now      <= r2_now;
            r3_item.win_done <= r2_done;
        end
    end

    assign o_push = r3_v;
    assign o_item = r3_item;

endmodule

// File: rtl/teq_fifo.sv
// ----------------------------------------------------------------------------
// teq_fifo
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
module teq_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_push_ready,
    input  teq_pkg::t_item  i_item,
    output logic            o_not_empty,
    input  logic            i_pop,
    output teq_pkg::t_item  o_item
);
    import teq_pkg::*;

    t_item                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  do_push, do_pop;

    assign o_push_ready = r_count != FIFO_CNT_W'(FIFO_DEPTH);
    assign o_not_empty  = r_count != '0;
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_not_empty;
    assign o_item       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (do_push && !do_pop) r_count <= r_count + 1'b1;
            else if (do_pop && !do_push) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_item;
    end

endmodule

// File: rtl/teq_back.sv
// ----------------------------------------------------------------------------
// teq_back
// Back end: cooldown check, window statistics, decision and result register.
// ----------------------------------------------------------------------------
module teq_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  teq_pkg::t_cfg     i_cfg,
    input  logic              i_not_empty,
    output logic              o_pop,
    input  teq_pkg::t_item    i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output teq_pkg::t_result  o_result
);
    import teq_pkg::*;

    logic [TIME_BITS-1:0]          r_last, n_last;
    logic [ENERGY_BITS-1:0]        r_energy, n_energy;
    logic [COUNT_BITS-1:0]         r_count, n_count;
    logic [ABS_BITS-1:0]           r_peak_abs, n_peak_abs;
    logic signed [SAMPLE_BITS-1:0] r_pos, n_pos, r_neg, n_neg;
    logic                          r_out_v;
    t_result                       r_out, n_out;
    logic                          n_emit;

    logic [TIME_BITS-1:0]          since;
    logic                          cool;
    logic [ENERGY_BITS:0]          esum;
    logic [ENERGY_BITS-1:0]        u_energy;
    logic [COUNT_BITS-1:0]         u_count;
    logic [ABS_BITS-1:0]           u_peak;
    logic signed [SAMPLE_BITS-1:0] u_pos, u_neg;
    logic signed [SAMPLE_BITS:0]   th_pos, th_neg;
    logic                          rebound;
    logic [MASK_BITS-1:0]          mask;

    assign o_pop = i_not_empty && (!r_out_v || i_ready);

    assign since  = i_item.now - r_last;
    assign cool   = since < TIME_BITS'(i_cfg.cooldown_ms);

    assign esum     = {1'b0, r_energy} + {1'b0, i_item.motion};
    assign u_energy = esum[ENERGY_BITS] ? {ENERGY_BITS{1'b1}} : esum[ENERGY_BITS-1:0];
    assign u_count  = (i_item.motion >= i_cfg.active_th && r_count != {COUNT_BITS{1'b1}})
                      ? r_count + 1'b1 : r_count;
    assign u_peak   = (i_item.abs_z > r_peak_abs) ? i_item.abs_z : r_peak_abs;
    assign u_pos    = (i_item.dz > r_pos) ? i_item.dz : r_pos;
    assign u_neg    = (i_item.dz < r_neg) ? i_item.dz : r_neg;

    assign th_pos  = $signed({{(SAMPLE_BITS + 1 - ABS_BITS){1'b0}}, i_cfg.rebound_th});
    assign th_neg  = -th_pos;
    assign rebound = ($signed({u_pos[SAMPLE_BITS-1], u_pos}) >= th_pos)
                  && ($signed({u_neg[SAMPLE_BITS-1], u_neg}) <= th_neg);

    always_comb begin
        mask = '0;
        mask[FAIL_PEAK]    = u_peak < i_cfg.peak_th;
        mask[FAIL_ENERGY]  = u_energy < i_cfg.energy_th;
        mask[FAIL_ACTIVE]  = u_count < i_cfg.active_need;
        mask[FAIL_REBOUND] = !rebound;
    end

    always_comb begin
        n_last     = r_last;
        n_energy   = r_energy;
        n_count    = r_count;
        n_peak_abs = r_peak_abs;
        n_pos      = r_pos;
        n_neg      = r_neg;
        n_emit     = 1'b0;
        n_out      = r_out;
        if (cool) begin
            // reject at once, leave the window alone
            n_emit              = 1'b1;
            n_out               = '0;
            n_out.fault_flags[FAIL_COOLDOWN] = 1'b1;
        end else if (i_item.win_done) begin
            n_emit         = 1'b1;
            n_out.accepted    = mask == '0;
            n_out.fault_flags = mask;
            n_out.peak_z      = u_peak;
            n_out.energy      = u_energy;
            n_out.active      = u_count;
            n_out.rebound     = rebound;
            if (mask == '0) n_last = i_item.now;
            n_energy   = '0;
            n_count    = '0;
            n_peak_abs = '0;
            n_pos      = '0;
            n_neg      = '0;
        end else begin
            n_energy   = u_energy;
            n_count    = u_count;
            n_peak_abs = u_peak;
            n_pos      = u_pos;
            n_neg      = u_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last     <= '0;
            r_energy   <= '0;
            r_count    <= '0;
            r_peak_abs <= '0;
            r_pos      <= '0;
            r_neg      <= '0;
            r_out_v    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_last     <= n_last;
                r_energy   <= n_energy;
                r_count    <= n_count;
                r_peak_abs <= n_peak_abs;
                r_pos      <= n_pos;
                r_neg      <= n_neg;
            end
            if (o_pop && n_emit) r_out_v <= 1'b1;
            else if (i_ready)    r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && n_emit) r_out <= n_out;
    end

    assign o_valid  = r_out_v;
    assign o_result = r_out;

endmodule

// File: rtl/tap_event_qualifier_unit.sv
// ----------------------------------------------------------------------------
// tap_event_qualifier_unit
// Qualifies accelerometer taps from 3-axis delta samples: cooldown, peak,
// energy, active count and Z rebound checks over a confirm window.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake                  Payload
// -------  ---------  -------------------------  --------------------------------
// in       slave      i_in_valid / o_in_ready    delta_x/y/z, now_ms, window_start_ms
// out      master     o_out_valid / i_out_ready  accepted, fault_flags, peak_z,
//                                                window_energy, active_samples,
//                                                rebound_seen
// cfg      slave      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One item per cycle sustained while the output is not stalled. From input
// accept to result valid, the accepting edge loads the first of three front
// stages (magnitudes, weighted sum, reciprocal multiply by 1/100), then one
// queue slot and the result register follow. The back stage updates the
// window statistics once per cycle, which sets the rate. Samples still inside
// the window produce no result unless rejected by cooldown.
// Reset is synchronous, active low; it restores register defaults and clears
// the window statistics and last accept time. A stalled output holds the back
// stage; the two-entry queue absorbs the front until it fills.
// ----------------------------------------------------------------------------
module tap_event_qualifier_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input samples
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [teq_pkg::SAMPLE_BITS-1:0]    i_delta_x,
    input  logic [teq_pkg::SAMPLE_BITS-1:0]    i_delta_y,
    input  logic [teq_pkg::SAMPLE_BITS-1:0]    i_delta_z,
    input  logic [teq_pkg::TIME_BITS-1:0]      i_now_ms,
    input  logic [teq_pkg::TIME_BITS-1:0]      i_window_start_ms,
    // results
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_accepted,
    output logic [teq_pkg::MASK_BITS-1:0]      o_fault_flags,
    output logic [teq_pkg::ABS_BITS-1:0]       o_peak_z,
    output logic [teq_pkg::ENERGY_BITS-1:0]    o_window_energy,
    output logic [teq_pkg::COUNT_BITS-1:0]     o_active_samples,
    output logic                               o_rebound_seen,
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [teq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [teq_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import teq_pkg::*;

    t_cfg    r_cfg;
    logic    push, push_ready, not_empty, pop;
    t_item   front_item, queue_item;
    t_result result;

    // Configuration registers: always ready, out-of-range indexes dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_PEAK_TH:     r_cfg.peak_th     <= i_cfg_data[14:0];
                REG_ENERGY_TH:   r_cfg.energy_th   <= i_cfg_data[15:0];
                REG_ACTIVE_TH:   r_cfg.active_th   <= i_cfg_data[15:0];
                REG_ACTIVE_NEED: r_cfg.active_need <= i_cfg_data[7:0];
                REG_REBOUND_TH:  r_cfg.rebound_th  <= i_cfg_data[14:0];
                REG_COOLDOWN:    r_cfg.cooldown_ms <= i_cfg_data[15:0];
                REG_CONFIRM:     r_cfg.confirm_ms  <= i_cfg_data[15:0];
                REG_WEIGHTS:     r_cfg.weights     <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // Front: classify each item and compute its weighted motion.
    teq_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_valid           (i_in_valid),
        .o_ready           (o_in_ready),
        .i_delta_x         (i_delta_x),
        .i_delta_y         (i_delta_y),
        .i_delta_z         (i_delta_z),
        .i_now_ms          (i_now_ms),
        .i_window_start_ms (i_window_start_ms),
        .o_push            (push),
        .i_push_ready      (push_ready),
        .o_item            (front_item)
    );

    // Queue: decouple front and back stalls.
    teq_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_item       (front_item),
        .o_not_empty  (not_empty),
        .i_pop        (pop),
        .o_item       (queue_item)
    );

    // Back: advance the window statistics and issue decisions.
    teq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_not_empty (not_empty),
        .o_pop       (pop),
        .i_item      (queue_item),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_result    (result)
    );

    assign o_accepted       = result.accepted;
    assign o_fault_flags    = result.fault_flags;
    assign o_peak_z         = result.peak_z;
    assign o_window_energy  = result.energy;
    assign o_active_samples = result.active;
    assign o_rebound_seen   = result.rebound;

endmodule
